// File: rtl/core/glq_pkg.sv
// ----------------------------------------------------------------------------
// glq_pkg
// shared types, codes and fixed-point helpers of the glyph quad layout unit
// ----------------------------------------------------------------------------
`default_nettype none

package glq_pkg;

  // sizing
  localparam int unsigned MAX_CHARS   = 1024;
  localparam int unsigned GLYPH_SLOTS = 256;
  localparam int unsigned SLOT_AW     = $clog2(GLYPH_SLOTS);
  localparam int unsigned CHARS_W     = $clog2(MAX_CHARS + 1);

  // fixed-point widths
  localparam int unsigned SC_W   = 28;  // scaled 12-bit pixel quantity
  localparam int unsigned SC14_W = 30;  // scaled 14-bit texel quantity
  localparam int unsigned WIDE_W = 30;  // unsaturated screen sum
  localparam int unsigned TEXS_W = 31;  // unsaturated texture sum

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_LAYOUT = 2'd1;
  localparam logic [1:0] REQ_BEGIN  = 2'd2;

  // fault codes
  localparam logic [1:0] FAULT_OK       = 2'd0;
  localparam logic [1:0] FAULT_MISSING  = 2'd1;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INV_HALF_W = 3'd0;
  localparam logic [2:0] REG_INV_HALF_H = 3'd1;
  localparam logic [2:0] REG_INV_TEX_W  = 3'd2;
  localparam logic [2:0] REG_INV_TEX_H  = 3'd3;
  localparam logic [2:0] REG_LINE_PITCH = 3'd4;

  // special character codes
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  // glyph table entry layouts
  typedef struct packed {
    logic [13:0] ax;
    logic [13:0] ay;
    logic [11:0] w;
    logic [11:0] h;
  } glyph_geom_t;

  typedef struct packed {
    logic [11:0]        adv;
    logic signed [11:0] bx;
    logic signed [11:0] by;
  } glyph_metr_t;

  localparam int unsigned GEOM_W = $bits(glyph_geom_t);
  localparam int unsigned METR_W = $bits(glyph_metr_t);

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_NEWLINE,
    KIND_GLYPH,
    KIND_FAULT
  } kind_e;

  // per-request control carried down the pipeline
  typedef struct packed {
    kind_e       kind;
    logic        emit;
    logic [1:0]  fault;
    logic [11:0] vertex;
  } item_t;

  // floor((pix * inv + 128) / 256)
  function automatic logic [SC_W-1:0] scale_u12(logic [11:0] pix, logic [23:0] inv);
    logic [35:0] prod;
    prod = {24'b0, pix} * {12'b0, inv};
    prod = prod + 36'd128;
    return prod[35:8];
  endfunction

  function automatic logic [SC14_W-1:0] scale_u14(logic [13:0] pix, logic [23:0] inv);
    logic [37:0] prod;
    prod = {24'b0, pix} * {14'b0, inv};
    prod = prod + 38'd128;
    return prod[37:8];
  endfunction

  function automatic logic signed [SC_W-1:0] scale_s12(logic signed [11:0] pix,
                                                       logic [23:0] inv);
    logic signed [36:0] prod;
    prod = pix * $signed({1'b0, inv});
    prod = prod + 37'sd128;
    return prod[35:8];
  endfunction

  function automatic logic signed [19:0] sat_scr(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 30'sd524287;
    lo = -30'sd524288;
    if (v > hi) begin
      return 20'sh7FFFF;
    end else if (v < lo) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

  function automatic logic [16:0] sat_tex(logic [TEXS_W-1:0] v);
    if (v > 31'd131071) begin
      return 17'h1FFFF;
    end
    return v[16:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/glq_ram.sv
// ----------------------------------------------------------------------------
// glq_ram
// generic single-write, single-read ram with a registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module glq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/glyph_quad_layout_unit.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_unit
// bitmap-font text layout: turns a character stream into textured quads
// ----------------------------------------------------------------------------
// The unit takes one request per clock unless stalled and returns a quad
// (or an error result) from its output register. Load requests fill a
// 256-entry glyph table held in two rams; lay-out requests read their glyph
// in the accept cycle, multiply its metrics by the configured reciprocals
// in the next stage, move the pen in the stage after that, and form the
// saturated edges in the last stage before the output register. The request
// rate is set by the single glyph read per request and the pen accumulator
// in stage two. Begin and load requests, newlines and spaces that have a
// glyph give no result, except for an overflow error. Each stage stalls
// only when the stage after it is full and blocked, so requests keep
// flowing into empty stages while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_layout_unit
  import glq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [13:0]        atlas_x_i,
  input  wire logic [13:0]        atlas_y_i,
  input  wire logic [11:0]        glyph_w_i,
  input  wire logic [11:0]        glyph_h_i,
  input  wire logic [11:0]        advance_i,
  input  wire logic signed [11:0] bear_x_i,
  input  wire logic signed [11:0] bear_y_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [19:0]      quad_x0_o,
  output logic signed [19:0]      quad_y0_o,
  output logic signed [19:0]      quad_x1_o,
  output logic signed [19:0]      quad_y1_o,
  output logic        [16:0]      tex_u0_o,
  output logic        [16:0]      tex_v0_o,
  output logic        [16:0]      tex_u1_o,
  output logic        [16:0]      tex_v1_o,
  output logic        [11:0]      first_vertex_o,
  output logic        [1:0]       fault_o
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] inv_half_w_q, inv_half_h_q, inv_tex_w_q, inv_tex_h_q;
  logic [11:0] line_pitch_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_half_w_q <= 24'd17476;
      inv_half_h_q <= 24'd31068;
      inv_tex_w_q  <= 24'd32768;
      inv_tex_h_q  <= 24'd32768;
      line_pitch_q <= 12'd16;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_INV_HALF_W: inv_half_w_q <= pwdata[23:0];
        REG_INV_HALF_H: inv_half_h_q <= pwdata[23:0];
        REG_INV_TEX_W:  inv_tex_w_q  <= pwdata[23:0];
        REG_INV_TEX_H:  inv_tex_h_q  <= pwdata[23:0];
        REG_LINE_PITCH: line_pitch_q <= pwdata[11:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_INV_HALF_W: prdata = {8'b0, inv_half_w_q};
      REG_INV_HALF_H: prdata = {8'b0, inv_half_h_q};
      REG_INV_TEX_W:  prdata = {8'b0, inv_tex_w_q};
      REG_INV_TEX_H:  prdata = {8'b0, inv_tex_h_q};
      REG_LINE_PITCH: prdata = {20'b0, line_pitch_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage moves when the next one has room
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic in_fire;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // accept stage: glyph table access and request bookkeeping
  // --------------------------------------------------------------------------
  logic [GLYPH_SLOTS-1:0] present_q;
  logic [CHARS_W-1:0]     chars_q, chars_d;
  logic                   fault_lat_q, fault_lat_d;
  logic [11:0]            vcount_q, vcount_d;
  logic [SLOT_AW-1:0]     slot;
  logic                   in_range;
  logic                   glyph_hit;
  logic                   tbl_we, tbl_re;
  logic                   s1_enter;
  item_t                  item_d;
  glyph_geom_t            geom_wr, geom_rd;
  glyph_metr_t            metr_wr, metr_rd;
  logic [GEOM_W-1:0]      geom_rdata;
  logic [METR_W-1:0]      metr_rdata;

  assign slot      = char_code_i[SLOT_AW-1:0];
  assign in_range  = ({1'b0, char_code_i} < 9'(GLYPH_SLOTS));
  assign glyph_hit = in_range && present_q[slot];
  assign tbl_we    = in_fire && (req_type_i == REQ_LOAD) && in_range;
  assign tbl_re    = in_fire && (req_type_i == REQ_LAYOUT) && in_range;

  assign geom_wr = '{ax: atlas_x_i, ay: atlas_y_i, w: glyph_w_i, h: glyph_h_i};
  assign metr_wr = '{adv: advance_i, bx: bear_x_i, by: bear_y_i};

  glq_ram #(
    .Width (GEOM_W),
    .Depth (GLYPH_SLOTS)
  ) u_geom_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot),
    .wdata_i (geom_wr),
    .re_i    (tbl_re),
    .raddr_i (slot),
    .rdata_o (geom_rdata)
  );

  glq_ram #(
    .Width (METR_W),
    .Depth (GLYPH_SLOTS)
  ) u_metr_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot),
    .wdata_i (metr_wr),
    .re_i    (tbl_re),
    .raddr_i (slot),
    .rdata_o (metr_rdata)
  );

  assign geom_rd = glyph_geom_t'(geom_rdata);
  assign metr_rd = glyph_metr_t'(metr_rdata);

  // classify the request; counters and latched fault move at accept time
  always_comb begin
    chars_d     = chars_q;
    fault_lat_d = fault_lat_q;
    vcount_d    = vcount_q;
    s1_enter    = 1'b0;
    item_d      = '{kind: KIND_FAULT, emit: 1'b0, fault: FAULT_OK, vertex: vcount_q};
    if (in_fire) begin
      case (req_type_i)
        REQ_BEGIN: begin
          chars_d     = '0;
          fault_lat_d = 1'b0;
          vcount_d    = '0;
          s1_enter    = 1'b1;
          item_d.kind = KIND_BEGIN;
        end
        REQ_LAYOUT: begin
          s1_enter = 1'b1;
          if (fault_lat_q || (chars_q >= CHARS_W'(MAX_CHARS))) begin
            // text too long: latch until the next begin
            fault_lat_d  = 1'b1;
            item_d.fault = FAULT_OVERFLOW;
          end else begin
            chars_d = chars_q + CHARS_W'(1);
            if (char_code_i == CODE_NEWLINE) begin
              item_d.kind = KIND_NEWLINE;
            end else if (!glyph_hit) begin
              item_d.fault = FAULT_MISSING;
            end else begin
              item_d.kind = KIND_GLYPH;
              item_d.emit = (char_code_i != CODE_SPACE);
              if (item_d.emit) begin
                vcount_d = vcount_q + 12'd4;
              end
            end
          end
        end
        default: ;  // loads and unknown codes leave the pipeline alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      chars_q     <= '0;
      fault_lat_q <= 1'b0;
      vcount_q    <= '0;
    end else begin
      if (tbl_we) begin
        present_q[slot] <= 1'b1;
      end
      chars_q     <= chars_d;
      fault_lat_q <= fault_lat_d;
      vcount_q    <= vcount_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: glyph data out of the rams, scale by the reciprocals
  // --------------------------------------------------------------------------
  item_t s1_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s1_enter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_item_q <= item_d;
    end
  end

  item_t                  s2_item_q;
  logic [SC_W-1:0]        s2_sw_q, s2_sh_q, s2_uw_q, s2_vh_q, s2_adv_q, s2_pitch_q;
  logic signed [SC_W-1:0] s2_bx_q, s2_by_q;
  logic [SC14_W-1:0]      s2_u0_q, s2_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // one multiplier per term, each rounded on its own
  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_item_q  <= s1_item_q;
      s2_sw_q    <= scale_u12(geom_rd.w, inv_half_w_q);
      s2_sh_q    <= scale_u12(geom_rd.h, inv_half_h_q);
      s2_bx_q    <= scale_s12(metr_rd.bx, inv_half_w_q);
      s2_by_q    <= scale_s12(metr_rd.by, inv_half_h_q);
      s2_u0_q    <= scale_u14(geom_rd.ax, inv_tex_w_q);
      s2_v0_q    <= scale_u14(geom_rd.ay, inv_tex_h_q);
      s2_uw_q    <= scale_u12(geom_rd.w, inv_tex_w_q);
      s2_vh_q    <= scale_u12(geom_rd.h, inv_tex_h_q);
      s2_adv_q   <= scale_u12(metr_rd.adv, inv_half_w_q);
      s2_pitch_q <= scale_u12(line_pitch_q, inv_half_h_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: pen accumulator and lower-left corner
  // --------------------------------------------------------------------------
  logic signed [19:0]       pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic                     s2_fire;
  logic                     s2_result;
  logic signed [WIDE_W-1:0] pen_x_w, pen_y_w;
  logic signed [WIDE_W-1:0] x0_w, y0_w;

  assign s2_fire   = s2_valid_q && s3_ready;
  assign s2_result = (s2_item_q.kind == KIND_FAULT) ||
                     ((s2_item_q.kind == KIND_GLYPH) && s2_item_q.emit);
  assign pen_x_w   = WIDE_W'(pen_x_q);
  assign pen_y_w   = WIDE_W'(pen_y_q);
  assign x0_w      = pen_x_w + WIDE_W'(s2_bx_q);
  assign y0_w      = pen_y_w + WIDE_W'(s2_by_q) - $signed({2'b00, s2_sh_q});

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (s2_fire) begin
      unique case (s2_item_q.kind)
        KIND_BEGIN: begin
          pen_x_d = '0;
          pen_y_d = sat_scr(-$signed({2'b00, s2_pitch_q}));
        end
        KIND_NEWLINE: begin
          pen_x_d = '0;
          pen_y_d = sat_scr(pen_y_w - $signed({2'b00, s2_pitch_q}));
        end
        KIND_GLYPH: begin
          pen_x_d = sat_scr(pen_x_w + $signed({2'b00, s2_adv_q}));
        end
        default: ;  // error results leave the pen alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

  item_t                    s3_item_q;
  logic signed [WIDE_W-1:0] s3_x0_q, s3_y0_q;
  logic [SC_W-1:0]          s3_sw_q, s3_sh_q, s3_uw_q, s3_vh_q;
  logic [SC14_W-1:0]        s3_u0_q, s3_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q && s2_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_item_q <= s2_item_q;
      s3_x0_q   <= x0_w;
      s3_y0_q   <= y0_w;
      s3_sw_q   <= s2_sw_q;
      s3_sh_q   <= s2_sh_q;
      s3_u0_q   <= s2_u0_q;
      s3_v0_q   <= s2_v0_q;
      s3_uw_q   <= s2_uw_q;
      s3_vh_q   <= s2_vh_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: far edges and saturation into the output register
  // --------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] x1_w, y1_w;
  logic [TEXS_W-1:0]        u1_w, v1_w;
  logic                     s3_ok;

  assign x1_w  = s3_x0_q + $signed({2'b00, s3_sw_q});
  assign y1_w  = s3_y0_q + $signed({2'b00, s3_sh_q});
  assign u1_w  = {1'b0, s3_u0_q} + {3'b000, s3_uw_q};
  assign v1_w  = {1'b0, s3_v0_q} + {3'b000, s3_vh_q};
  assign s3_ok = (s3_item_q.kind == KIND_GLYPH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s3_valid_q;
    end
  end

  // error results carry the fault code only
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      quad_x0_o      <= s3_ok ? sat_scr(s3_x0_q) : '0;
      quad_y0_o      <= s3_ok ? sat_scr(s3_y0_q) : '0;
      quad_x1_o      <= s3_ok ? sat_scr(x1_w) : '0;
      quad_y1_o      <= s3_ok ? sat_scr(y1_w) : '0;
      tex_u0_o       <= s3_ok ? sat_tex({1'b0, s3_u0_q}) : '0;
      tex_v0_o       <= s3_ok ? sat_tex({1'b0, s3_v0_q}) : '0;
      tex_u1_o       <= s3_ok ? sat_tex(u1_w) : '0;
      tex_v1_o       <= s3_ok ? sat_tex(v1_w) : '0;
      first_vertex_o <= s3_ok ? s3_item_q.vertex : '0;
      fault_o        <= s3_item_q.fault;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_chars_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= CHARS_W'(MAX_CHARS))
    else $error("character count beyond limit");

  a_overflow_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i == REQ_LAYOUT) && (chars_q == CHARS_W'(MAX_CHARS)))
    |=> fault_lat_q)
    else $error("overflow did not latch");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fault_o != FAULT_OK)) |->
    ((quad_x0_o == '0) && (quad_y1_o == '0) && (tex_u0_o == '0) &&
     (tex_v1_o == '0) && (first_vertex_o == '0)))
    else $error("error result with nonzero fields");

  a_vertex_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_vertex_o[1:0] == 2'b00))
    else $error("vertex index not a multiple of four");

  a_edges_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fault_o == FAULT_OK)) |->
    ((quad_x1_o >= quad_x0_o) && (quad_y1_o >= quad_y0_o) &&
     (tex_u1_o >= tex_u0_o) && (tex_v1_o >= tex_v0_o)))
    else $error("quad edges out of order");
`endif

endmodule

`default_nettype wire
